>>> rtl/blf_pkg.sv
// Shared types and constants for the backlight linear fader.
// Has no dependencies; every other file of the block but the RAM uses it.
package blf_pkg;

    // Default number of channel records
    localparam int CHANNELS_DEF = 8;

    // Field widths
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int CH_W    = 3;
    localparam int OP_W    = 2;
    localparam int CIU_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_FADE = 2'd1;
    localparam logic [OP_W-1:0] OP_POLL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 1'd1;

    // Input request
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] target_level;
        logic [DUR_W-1:0]   fade_time_ms;
        logic [TIME_W-1:0]  now_ms;
    } fader_in_t;

    // Result
    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] out_level;
        logic               last;
    } fader_out_t;

    // One channel record as stored in memory
    typedef struct packed {
        logic               fading;
        logic [LEVEL_W-1:0] current_level;
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] end_level;
        logic [TIME_W-1:0]  start_time;
        logic [DUR_W-1:0]   duration;
    } fader_entry_t;

    // Record value of a channel never written since reset
    localparam fader_entry_t ENTRY_RESET = '{
        fading:        1'b0,
        current_level: 16'hFFFF,
        start_level:   16'hFFFF,
        end_level:     16'hFFFF,
        start_time:    32'd0,
        duration:      16'd0
    };

endpackage

>>> rtl/blf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the channel records of the fader.
module blf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_q[rd_addr];
        end
    end

endmodule

>>> rtl/blf_divider.sv
// Radix-4 restoring divider: 32-bit dividend by 16-bit divisor, 16-bit quotient.
// Uses blf_pkg widths; the caller guarantees dividend[31:16] < divisor.
module blf_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2*blf_pkg::DUR_W-1:0]  dividend,
    input  logic [blf_pkg::DUR_W-1:0]    divisor,
    output logic                         done,
    output logic [blf_pkg::DUR_W-1:0]    quotient
);

    localparam int DW    = blf_pkg::DUR_W;
    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] qsh_reg, qsh_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   s1, s2;

    // One restoring step: shift in a bit, subtract if it fits; returns {qbit, rem}
    function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {1'b1, diff[DW-1:0]};
        end
        return {1'b0, t[DW-1:0]};
    endfunction

    // Two quotient bits per cycle
    always_comb
    begin
        s1 = div_step(rem_reg, qsh_reg[DW-1], dvs_reg);
        s2 = div_step(s1[DW-1:0], qsh_reg[DW-2], dvs_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qsh_next  = qsh_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[2*DW-1:DW];
            qsh_next  = dividend[DW-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = s2[DW-1:0];
            qsh_next = {qsh_reg[DW-3:0], s1[DW], s2[DW]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        qsh_reg <= qsh_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = qsh_reg;

endmodule

>>> rtl/backlight_linear_fader_core.sv
// Top level of the backlight linear fader: request FSM around the record RAM.
// Depends on blf_pkg, blf_ram and blf_divider.
//
// Keeps a level and a linear fade record per channel in one RAM, one record
// per channel, read via a registered port and written back after update. A
// set request steps through accept, record read and write back, and result
// release; a fade request through accept and record read and write back,
// unless zero duration or an unchanged level makes it act as a set. A poll
// walks channels 0 to min(channels_in_use, CHANNELS)-1 after its accept: a
// channel not fading takes the read alone, one whose fade ends the read,
// elapsed check and write back, and one in mid-fade the read, the elapsed
// check with the 16x16 multiply, the radix-4 divide, the quotient hand-over
// and the write back; the last result is then released. Results of a poll
// are held one deep so the final one carries last; a write back or release
// that must move a held result waits while the output register is stalled;
// the next request is accepted while the final result still waits there.
// Records unwritten since reset read full level, not fading; no clearing pass.
module backlight_linear_fader_core #(
    parameter int CHANNELS = blf_pkg::CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  blf_pkg::fader_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output blf_pkg::fader_out_t              out_data,
    input  logic                             cfg_write,
    input  logic [blf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [blf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);
    localparam int LW   = (CNTW > blf_pkg::CIU_W) ? CNTW : blf_pkg::CIU_W;
    localparam int EW   = $bits(blf_pkg::fader_entry_t);
    localparam int LVW  = blf_pkg::LEVEL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD    = 6'b000010,
        S_CHK   = 6'b000100,
        S_DIV   = 6'b001000,
        S_UPD   = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [LVW-1:0]               max_level_reg, max_level_next;
    logic [blf_pkg::CIU_W-1:0]    ciu_reg, ciu_next;
    logic [CHANNELS-1:0]          written_reg, written_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         out_valid_reg, out_valid_next;

    logic [blf_pkg::OP_W-1:0]     op_reg, op_next;
    logic [LVW-1:0]               lvl_reg, lvl_next;
    logic [blf_pkg::DUR_W-1:0]    dur_reg, dur_next;
    logic [blf_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [LW-1:0]                idx_reg, idx_next;
    logic [LW-1:0]                lim_reg, lim_next;
    blf_pkg::fader_entry_t        ent_reg, ent_next;
    logic [blf_pkg::TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                         span_neg_reg, span_neg_next;
    logic [LVW-1:0]               span_mag_reg, span_mag_next;
    logic [LVW-1:0]               new_lvl_reg, new_lvl_next;
    logic                         fin_reg, fin_next;
    logic                         rd_ok_reg, rd_ok_next;
    blf_pkg::fader_out_t          pend_reg, pend_next;
    blf_pkg::fader_out_t          out_reg, out_next;

    logic                         rd_en, wr_en;
    logic [AW-1:0]                rd_addr, wr_addr;
    blf_pkg::fader_entry_t        wr_entry, ent_rd;
    logic [EW-1:0]                rd_data;
    logic                         div_start, div_done;
    logic [2*blf_pkg::DUR_W-1:0]  div_dividend;
    logic [blf_pkg::DUR_W-1:0]    div_quotient;
    logic [LW-1:0]                lim_calc, idx_inc;
    logic [LVW-1:0]               lvl_clamped;
    logic                         can_push;

    // Record store
    blf_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Interpolation divider
    blf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ent_reg.duration),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Records never written read as the reset record
    assign ent_rd = rd_ok_reg ? blf_pkg::fader_entry_t'(rd_data) : blf_pkg::ENTRY_RESET;

    // Poll range, saturated at the channel count
    assign lim_calc = (32'(ciu_reg) > CHANNELS) ? LW'(CHANNELS) : LW'(ciu_reg);
    assign idx_inc  = idx_reg + 1'b1;

    assign lvl_clamped = (in_data.target_level > max_level_reg) ? max_level_reg
                                                                : in_data.target_level;
    assign div_dividend = (2*blf_pkg::DUR_W)'(span_mag_reg)
                        * (2*blf_pkg::DUR_W)'(elapsed_reg[blf_pkg::DUR_W-1:0]);
    assign can_push     = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Request sequencer
    always_comb
    begin
        state_next      = state_reg;
        written_next    = written_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        lvl_next        = lvl_reg;
        dur_next        = dur_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        ent_next        = ent_reg;
        elapsed_next    = elapsed_reg;
        span_neg_next   = span_neg_reg;
        span_mag_next   = span_mag_reg;
        new_lvl_next    = new_lvl_reg;
        fin_next        = fin_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_entry        = ent_reg;
        div_start       = 1'b0;

        // Drop a result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.operation;
                    lvl_next = lvl_clamped;
                    dur_next = in_data.fade_time_ms;
                    now_next = in_data.now_ms;
                    lim_next = lim_calc;
                    case (in_data.operation)
                        blf_pkg::OP_SET, blf_pkg::OP_FADE:
                        begin
                            idx_next = LW'(in_data.channel);
                            if (32'(in_data.channel) < CHANNELS)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_data.channel);
                                state_next = S_RD;
                            end
                        end
                        blf_pkg::OP_POLL:
                        begin
                            idx_next = '0;
                            if (lim_calc != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                ent_next     = ent_rd;
                elapsed_next = now_reg - ent_rd.start_time;
                if (ent_rd.end_level >= ent_rd.start_level)
                begin
                    span_neg_next = 1'b0;
                    span_mag_next = ent_rd.end_level - ent_rd.start_level;
                end
                else
                begin
                    span_neg_next = 1'b1;
                    span_mag_next = ent_rd.start_level - ent_rd.end_level;
                end
                if (op_reg == blf_pkg::OP_POLL)
                begin
                    if (ent_rd.fading)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        // Advance to the next channel
                        idx_next = idx_inc;
                        if (idx_inc < lim_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_inc[AW-1:0];
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
                else if (op_reg == blf_pkg::OP_FADE && dur_reg != '0
                         && lvl_reg != ent_rd.current_level)
                begin
                    // Start a fade from the present level
                    wr_en                = 1'b1;
                    wr_entry             = ent_rd;
                    wr_entry.fading      = 1'b1;
                    wr_entry.start_level = ent_rd.current_level;
                    wr_entry.end_level   = lvl_reg;
                    wr_entry.start_time  = now_reg;
                    wr_entry.duration    = dur_reg;
                    written_next[wr_addr] = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    // Set the level at once and report it
                    wr_en                  = 1'b1;
                    wr_entry               = ent_rd;
                    wr_entry.fading        = 1'b0;
                    wr_entry.current_level = lvl_reg;
                    written_next[wr_addr]  = 1'b1;
                    pend_valid_next        = 1'b1;
                    pend_next.out_channel  = idx_reg[blf_pkg::CH_W-1:0];
                    pend_next.out_level    = lvl_reg;
                    pend_next.last         = 1'b1;
                    state_next             = S_FLUSH;
                end
            end

            S_CHK:
            begin
                if (elapsed_reg >= 32'(ent_reg.duration))
                begin
                    new_lvl_next = ent_reg.end_level;
                    fin_next     = 1'b1;
                    state_next   = S_UPD;
                end
                else
                begin
                    fin_next   = 1'b0;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    new_lvl_next = span_neg_reg ? ent_reg.start_level - div_quotient
                                                : ent_reg.start_level + div_quotient;
                    state_next   = S_UPD;
                end
            end

            S_UPD:
            begin
                if (new_lvl_reg == ent_reg.current_level || !pend_valid_reg || can_push)
                begin
                    wr_entry               = ent_reg;
                    wr_entry.fading        = !fin_reg;
                    wr_entry.current_level = new_lvl_reg;
                    wr_en = fin_reg || (new_lvl_reg != ent_reg.current_level);
                    if (wr_en)
                    begin
                        written_next[wr_addr] = 1'b1;
                    end
                    if (new_lvl_reg != ent_reg.current_level)
                    begin
                        // Release the held result and hold the new one
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_valid_next       = 1'b1;
                        pend_next.out_channel = idx_reg[blf_pkg::CH_W-1:0];
                        pend_next.out_level   = new_lvl_reg;
                        pend_next.last        = 1'b0;
                    end
                    // Advance to the next channel
                    idx_next = idx_inc;
                    if (idx_inc < lim_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_inc[AW-1:0];
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_comb
    begin
        max_level_next = max_level_reg;
        ciu_next       = ciu_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                blf_pkg::REG_MAX_LEVEL:       max_level_next = cfg_data;
                blf_pkg::REG_CHANNELS_IN_USE: ciu_next = cfg_data[blf_pkg::CIU_W-1:0];
                default:                      max_level_next = max_level_reg;
            endcase
        end
    end

    // Latch the written flag of the record being read
    assign rd_ok_next = rd_en ? written_reg[rd_addr] : rd_ok_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_level_reg  <= '1;
            ciu_reg        <= '0;
            written_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_level_reg  <= max_level_next;
            ciu_reg        <= ciu_next;
            written_reg    <= written_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        lvl_reg      <= lvl_next;
        dur_reg      <= dur_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        ent_reg      <= ent_next;
        elapsed_reg  <= elapsed_next;
        span_neg_reg <= span_neg_next;
        span_mag_reg <= span_mag_next;
        new_lvl_reg  <= new_lvl_next;
        fin_reg      <= fin_next;
        rd_ok_reg    <= rd_ok_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

endmodule

>>> rtl/blf_checker.sv
// Port-level assertions for backlight_linear_fader_core, attached by bind.
// Depends on blf_pkg.
module blf_checker #(
    parameter int CHANNELS = blf_pkg::CHANNELS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input blf_pkg::fader_in_t               in_data,
    input logic                             out_valid,
    input logic                             out_ready,
    input blf_pkg::fader_out_t              out_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A set or fade on a real channel keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (32'(in_data.channel) < CHANNELS)
        && (in_data.operation == blf_pkg::OP_SET || in_data.operation == blf_pkg::OP_FADE)
        |=> !in_ready)
        else $error("set or fade request not processed");

    // An unused operation code is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation != blf_pkg::OP_SET
        && in_data.operation != blf_pkg::OP_FADE && in_data.operation != blf_pkg::OP_POLL
        |=> in_ready)
        else $error("unused operation stalled the block");

    // A result without last means the poll is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("poll ended without a final result");

endmodule

bind backlight_linear_fader_core blf_checker #(.CHANNELS(CHANNELS)) u_blf_checker (.*);

>>> verif/tb_backlight_linear_fader_core.sv
// Testbench for backlight_linear_fader_core: directed and random set, fade and poll
// requests checked against an in-bench model of the channel levels and fades.
// Depends on blf_pkg and the core RTL; drives the valid/ready channels and config port.
module tb_backlight_linear_fader_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH = blf_pkg::CHANNELS_DEF;
    localparam int CLK_HALF = 5;
    localparam int DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 600000;
    // Operation code the block must ignore
    localparam logic [blf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    blf_pkg::fader_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    blf_pkg::fader_out_t out_data;
    logic cfg_write = 1'b0;
    logic [blf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [blf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted channel records and registers
    logic [blf_pkg::LEVEL_W-1:0] ch_level [NUM_CH];
    logic                        ch_fading [NUM_CH];
    logic [blf_pkg::LEVEL_W-1:0] ch_from [NUM_CH];
    logic [blf_pkg::LEVEL_W-1:0] ch_to [NUM_CH];
    logic [blf_pkg::TIME_W-1:0]  ch_t0 [NUM_CH];
    logic [blf_pkg::DUR_W-1:0]   ch_len [NUM_CH];
    logic [blf_pkg::LEVEL_W-1:0] reg_max_level;
    logic [blf_pkg::CIU_W-1:0]   reg_chan_count;

    // Level updates predicted but not yet seen on the output
    blf_pkg::fader_out_t pending_updates [$];
    blf_pkg::fader_out_t oldest_update;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [blf_pkg::TIME_W-1:0] ms_clock = '0;
    int error_count = 0;
    int checked_count = 0;
    int request_count = 0;
    int poll_count = 0;
    int fade_count = 0;
    longint cycle_count = 0;

    backlight_linear_fader_core #(
        .CHANNELS(NUM_CH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d level updates outstanding",
                     cycle_count, pending_updates.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result channel at the phase's rate
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Compare every accepted result with the oldest predicted update
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
                flag_mismatch($sformatf("unexpected update ch %0d level %0d last %0b",
                                        out_data.out_channel, out_data.out_level,
                                        out_data.last));
            else
            begin
                oldest_update = pending_updates.pop_front();
                if (out_data.out_channel !== oldest_update.out_channel
                    || out_data.out_level !== oldest_update.out_level
                    || out_data.last !== oldest_update.last)
                    flag_mismatch($sformatf(
                        "got ch %0d level %0d last %0b, want ch %0d level %0d last %0b",
                        out_data.out_channel, out_data.out_level,
                        out_data.last, oldest_update.out_channel,
                        oldest_update.out_level, oldest_update.last));
                checked_count++;
            end
        end
    end

    task automatic reset_levels();
        reg_max_level = 16'hFFFF;
        reg_chan_count = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            ch_level[i] = 16'hFFFF;
            ch_fading[i] = 1'b0;
            ch_from[i] = 16'hFFFF;
            ch_to[i] = 16'hFFFF;
            ch_t0[i] = '0;
            ch_len[i] = '0;
        end
    endtask

    // Advance one channel's fade to the given time; return 1 if its level moved
    function automatic bit advance_fade(input int idx, input logic [blf_pkg::TIME_W-1:0] now);
        logic [blf_pkg::TIME_W-1:0] elapsed;
        logic [blf_pkg::LEVEL_W-1:0] next_level;
        longint from_l;
        longint to_l;
        longint el_l;
        longint len_l;
        longint offset;
        longint sum;
        if (!ch_fading[idx])
            return 1'b0;
        elapsed = now - ch_t0[idx];
        if (elapsed >= ch_len[idx])
        begin
            next_level = ch_to[idx];
            ch_fading[idx] = 1'b0;
        end
        else
        begin
            from_l = ch_from[idx];
            to_l = ch_to[idx];
            el_l = elapsed;
            len_l = ch_len[idx];
            // signed divide truncates toward zero
            offset = ((to_l - from_l) * el_l) / len_l;
            sum = from_l + offset;
            next_level = sum[blf_pkg::LEVEL_W-1:0];
        end
        if (next_level == ch_level[idx])
            return 1'b0;
        ch_level[idx] = next_level;
        return 1'b1;
    endfunction

    // Update the model for one accepted request and queue its level updates
    task automatic predict_level_updates(input blf_pkg::fader_in_t req);
        logic [blf_pkg::LEVEL_W-1:0] lvl;
        blf_pkg::fader_out_t upd;
        blf_pkg::fader_out_t poll_updates [$];
        int lim;
        if (req.operation == blf_pkg::OP_SET || req.operation == blf_pkg::OP_FADE)
        begin
            lvl = (req.target_level > reg_max_level) ? reg_max_level : req.target_level;
            if (req.operation == blf_pkg::OP_FADE && req.fade_time_ms != '0
                && lvl != ch_level[req.channel])
            begin
                // start a fade from the present level; nothing is emitted
                ch_from[req.channel] = ch_level[req.channel];
                ch_to[req.channel] = lvl;
                ch_t0[req.channel] = req.now_ms;
                ch_len[req.channel] = req.fade_time_ms;
                ch_fading[req.channel] = 1'b1;
                fade_count++;
            end
            else
            begin
                ch_fading[req.channel] = 1'b0;
                ch_level[req.channel] = lvl;
                upd.out_channel = req.channel;
                upd.out_level = lvl;
                upd.last = 1'b1;
                pending_updates.push_back(upd);
            end
        end
        else if (req.operation == blf_pkg::OP_POLL)
        begin
            lim = (reg_chan_count > NUM_CH) ? NUM_CH : int'(reg_chan_count);
            for (int i = 0; i < lim; i++)
            begin
                if (advance_fade(i, req.now_ms))
                begin
                    upd.out_channel = blf_pkg::CH_W'(i);
                    upd.out_level = ch_level[i];
                    upd.last = 1'b0;
                    poll_updates.push_back(upd);
                end
            end
            if (poll_updates.size() > 0)
                poll_updates[poll_updates.size() - 1].last = 1'b1;
            foreach (poll_updates[k])
                pending_updates.push_back(poll_updates[k]);
        end
    endtask

    // Present one request, hold it until accepted, then predict its updates
    task automatic send_request(input blf_pkg::fader_in_t req);
        // Idle the sender at the phase's rate, drawing afresh each time
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (!in_ready);
        predict_level_updates(req);
        request_count++;
        if (req.operation == blf_pkg::OP_POLL)
            poll_count++;
    endtask

    // Drop valid, wait for all predicted updates, then let the block go quiet
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [blf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [blf_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == blf_pkg::REG_MAX_LEVEL)
            reg_max_level = value;
        else if (idx == blf_pkg::REG_CHANNELS_IN_USE)
            reg_chan_count = value[blf_pkg::CIU_W-1:0];
    endtask

    task automatic configure(input logic [blf_pkg::CFG_DATA_W-1:0] max_lvl,
                             input logic [blf_pkg::CIU_W-1:0] count);
        wait_for_results();
        write_reg(blf_pkg::REG_MAX_LEVEL, max_lvl);
        write_reg(blf_pkg::REG_CHANNELS_IN_USE, blf_pkg::CFG_DATA_W'(count));
    endtask

    function automatic blf_pkg::fader_in_t make_request(
        input logic [blf_pkg::OP_W-1:0] op,
        input logic [blf_pkg::CH_W-1:0] ch,
        input logic [blf_pkg::LEVEL_W-1:0] lvl,
        input logic [blf_pkg::DUR_W-1:0] dur,
        input logic [blf_pkg::TIME_W-1:0] now);
        blf_pkg::fader_in_t req;
        req.operation = op;
        req.channel = ch;
        req.target_level = lvl;
        req.fade_time_ms = dur;
        req.now_ms = now;
        return req;
    endfunction

    // Polls at advancing time, fades and sets on mostly polled channels, unused codes, noise
    function automatic blf_pkg::fader_in_t random_request();
        blf_pkg::fader_in_t req;
        int pick;
        int kind;
        int lim;
        lim = (reg_chan_count > NUM_CH) ? NUM_CH : int'(reg_chan_count);
        pick = $urandom_range(99);
        req.channel = (lim > 0 && $urandom_range(99) < 80)
                    ? blf_pkg::CH_W'($urandom_range(lim - 1))
                    : blf_pkg::CH_W'($urandom_range(NUM_CH - 1));
        kind = $urandom_range(99);
        if (kind < 60)
            req.target_level = blf_pkg::LEVEL_W'($urandom);
        else if (kind < 80)
            req.target_level = kind[0] ? 16'hFFFF : 16'h0000;
        else
            req.target_level = reg_max_level - blf_pkg::LEVEL_W'($urandom_range(3));
        kind = $urandom_range(99);
        if (kind < 65)
            req.fade_time_ms = blf_pkg::DUR_W'($urandom_range(1, 120));
        else if (kind < 80)
            req.fade_time_ms = blf_pkg::DUR_W'($urandom);
        else if (kind < 90)
            req.fade_time_ms = '0;
        else
            req.fade_time_ms = blf_pkg::DUR_W'($urandom_range(1, 3000));
        req.now_ms = ($urandom_range(99) < 10) ? blf_pkg::TIME_W'($urandom) : ms_clock;
        if (pick < 36)
        begin
            req.operation = blf_pkg::OP_POLL;
            if ($urandom_range(99) < 3)
                ms_clock = ms_clock + blf_pkg::TIME_W'($urandom);
            else
                ms_clock = ms_clock + blf_pkg::TIME_W'($urandom_range(0, 30));
            req.now_ms = ms_clock;
        end
        else if (pick < 70)
            req.operation = blf_pkg::OP_FADE;
        else if (pick < 88)
            req.operation = blf_pkg::OP_SET;
        else if (pick < 93)
            req.operation = OP_UNUSED;
        else
        begin
            // noise: every field random
            req.operation = blf_pkg::OP_W'($urandom_range(3));
            req.channel = blf_pkg::CH_W'($urandom);
            req.target_level = blf_pkg::LEVEL_W'($urandom);
            req.fade_time_ms = blf_pkg::DUR_W'($urandom);
            req.now_ms = blf_pkg::TIME_W'($urandom);
        end
        return req;
    endfunction

    task automatic run_random(input int n);
        blf_pkg::fader_in_t req;
        for (int sent = 0; sent < n; sent++)
        begin
            req = random_request();
            send_request(req);
        end
    endtask

    // Extremes of every field, each operation and each corner of the fade rules
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_stall_pct = 25;
        configure(16'hFFFF, 4'd8);
        send_request(make_request(blf_pkg::OP_SET, 3'd0, 16'h0000, 16'd0, 32'd0));
        send_request(make_request(blf_pkg::OP_SET, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        // zero duration acts as a set
        send_request(make_request(blf_pkg::OP_FADE, 3'd1, 16'd1000, 16'd0, 32'd0));
        // level equal to the current one acts as a set
        send_request(make_request(blf_pkg::OP_FADE, 3'd2, 16'hFFFF, 16'd100, 32'd0));
        // downward fade across the time wrap
        send_request(make_request(blf_pkg::OP_FADE, 3'd3, 16'h0000, 16'd100, 32'hFFFF_FFC0));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'hFFFF_FFF0));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'h0000_0010));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'h0000_0030));
        // longest fade; zero elapsed leaves the level alone
        send_request(make_request(blf_pkg::OP_FADE, 3'd0, 16'hFFFF, 16'hFFFF, 32'd5));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd5));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd6));
        // fade while fading restarts from the present level
        send_request(make_request(blf_pkg::OP_FADE, 3'd0, 16'd100, 16'd10, 32'd1000));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd1005));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd1010));
        send_request(make_request(OP_UNUSED, 3'd5, 16'h1234, 16'd9, 32'd1011));
        // several channels move in one poll
        send_request(make_request(blf_pkg::OP_FADE, 3'd4, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_request(blf_pkg::OP_FADE, 3'd5, 16'd12345, 16'd1, 32'd2000));
        send_request(make_request(blf_pkg::OP_FADE, 3'd6, 16'h0000, 16'd3, 32'd2000));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd2001));
        // lower max: new requests clamp, stored levels stay
        configure(16'd1000, 4'd8);
        send_request(make_request(blf_pkg::OP_SET, 3'd5, 16'd40000, 16'd0, 32'd2002));
        send_request(make_request(blf_pkg::OP_FADE, 3'd1, 16'hFFFF, 16'd50, 32'd2002));
        send_request(make_request(blf_pkg::OP_FADE, 3'd7, 16'd500, 16'd4, 32'd3000));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd3002));
        // no channels polled, but set still acts
        configure(16'd1000, 4'd0);
        send_request(make_request(blf_pkg::OP_SET, 3'd6, 16'd777, 16'd0, 32'd3003));
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd9000));
        // channel count above the number of channels saturates
        configure(16'd1000, 4'd15);
        send_request(make_request(blf_pkg::OP_POLL, 3'd0, 16'd0, 16'd0, 32'd9001));
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct,
                                     input logic [blf_pkg::CFG_DATA_W-1:0] max_lvl,
                                     input logic [blf_pkg::CIU_W-1:0] count);
        configure(max_lvl, count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        run_random(n);
    endtask

    // Level register at its limits and odd channel counts
    task automatic test_register_extremes();
        test_random_phase(30, 10, 10, 16'h0000, 4'd8);
        test_random_phase(20, 10, 10, 16'h0001, 4'd0);
        test_random_phase(20, 10, 10, 16'hFFFF, 4'd1);
    endtask

    // Hold the sender until every update has drained, then resume mid-phase
    task automatic test_drain_pause();
        configure(16'hFFFF, 4'd8);
        send_idle_pct = 48;
        recv_stall_pct = 48;
        run_random(20);
        wait_for_results();
        run_random(20);
    endtask

    initial
    begin
        reset_levels();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_phase(90, 0, 0, 16'hFFFF, 4'd8);
        test_random_phase(90, 48, 0, 16'd40000, 4'd15);
        test_random_phase(90, 0, 48, 16'd20000, 4'd5);
        ms_clock = 32'hFFFF_F800;
        test_random_phase(90, 10, 10, 16'hFFFF, 4'd8);
        test_register_extremes();
        test_drain_pause();

        wait_for_results();
        $display("Ran %0d requests (%0d polls, %0d fades started), checked %0d level updates",
                 request_count, poll_count, fade_count, checked_count);
        $display("Covered level limits 0 to 65535, channel counts 0 to 15 and four idle mixes");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
